/* rtl/chkv_pkg.sv */
// Shared types and constants of the chained hash key-value store.
package chkv_pkg;
   localparam int HASH_BITS    = 12;
   localparam int POOL_NODES   = 16384;
   localparam int KEY_LETTERS  = 10;
   localparam int LETTER_BITS  = 5;
   localparam int KEY_W        = LETTER_BITS * KEY_LETTERS;
   localparam int DATA_W       = 32;
   localparam int BUCKETS      = 1 << HASH_BITS;
   localparam int NODE_BITS    = $clog2(POOL_NODES);
   localparam int POOL_CNT_W   = $clog2(POOL_NODES + 1);
   localparam int LETTER_CNT_W = $clog2(KEY_LETTERS + 1);
   localparam int HASH_START   = 5381;
   localparam int Q_DEPTH      = 2;
   localparam int QPTR_W       = $clog2(Q_DEPTH);
   localparam int QCNT_W       = $clog2(Q_DEPTH + 1);
   localparam int REQ_TDATA_W  = ((KEY_W + DATA_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_POOL_FULL = 2'd2
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic [KEY_W-1:0]       key;
      logic [DATA_W-1:0]      data;
      logic [HASH_BITS-1:0]   bucket;
   } job_type;

   typedef struct packed {
      logic                 vld;
      logic [NODE_BITS-1:0] idx;
   } link_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_HASH,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_SWEEP,
      B_IDLE,
      B_HEAD,
      B_NODE
   } back_state_type;
endpackage

/* rtl/chkv_front.sv */
// Front end: takes a request, trims the key and hashes it one letter per cycle.
module chkv_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_type,
   input  logic [chkv_pkg::KEY_W-1:0]          key_chars,
   input  logic [chkv_pkg::DATA_W-1:0]         data_in,
   input  logic                                init_busy,
   output logic                                push_valid,
   output chkv_pkg::job_type                   push_job,
   input  logic                                q_full
);
   chkv_pkg::front_state_type state_ff, state_in;
   logic [chkv_pkg::KEY_W-1:0]        raw_ff, raw_in;
   logic [chkv_pkg::KEY_W-1:0]        norm_ff, norm_in;
   logic [chkv_pkg::HASH_BITS-1:0]    hash_ff, hash_in;
   logic [chkv_pkg::LETTER_CNT_W-1:0] cnt_ff, cnt_in;
   logic                              stop_ff, stop_in;
   chkv_pkg::op_type                  op_ff, op_in;
   logic [chkv_pkg::DATA_W-1:0]       value_ff, value_in;
   logic [chkv_pkg::LETTER_BITS-1:0]  letter;
   logic                              keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chkv_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      raw_ff   <= raw_in;
      norm_ff  <= norm_in;
      hash_ff  <= hash_in;
      cnt_ff   <= cnt_in;
      stop_ff  <= stop_in;
      op_ff    <= op_in;
      value_ff <= value_in;
   end

   assign letter = raw_ff[chkv_pkg::LETTER_BITS-1:0];
   assign keep   = !stop_ff && (letter != '0);

   always_comb begin
      state_in   = state_ff;
      raw_in     = raw_ff;
      norm_in    = norm_ff;
      hash_in    = hash_ff;
      cnt_in     = cnt_ff;
      stop_in    = stop_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         chkv_pkg::F_IDLE: begin
            req_tready = !init_busy;
            if (req_tvalid && !init_busy) begin
               raw_in    = key_chars;
               norm_in   = '0;
               hash_in   = chkv_pkg::HASH_BITS'(chkv_pkg::HASH_START);
               cnt_in    = '0;
               stop_in   = 1'b0;
               op_in     = chkv_pkg::op_type'(req_type);
               value_in  = data_in;
               state_in  = chkv_pkg::F_HASH;
            end
         end
         chkv_pkg::F_HASH: begin
            raw_in  = raw_ff >> chkv_pkg::LETTER_BITS;
            norm_in = (norm_ff >> chkv_pkg::LETTER_BITS) |
                      (chkv_pkg::KEY_W'(keep ? letter : '0)
                       << (chkv_pkg::KEY_W - chkv_pkg::LETTER_BITS));
            if (keep) begin
               hash_in = (hash_ff << 5) + hash_ff + chkv_pkg::HASH_BITS'(letter);
            end
            stop_in = !keep;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == chkv_pkg::LETTER_CNT_W'(chkv_pkg::KEY_LETTERS - 1)) begin
               state_in = chkv_pkg::F_PUSH;
            end
         end
         chkv_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (!q_full) begin
               state_in = chkv_pkg::F_IDLE;
            end
         end
         default: state_in = chkv_pkg::F_IDLE;
      endcase
   end

   assign push_job.op     = op_ff;
   assign push_job.key    = norm_ff;
   assign push_job.data   = value_ff;
   assign push_job.bucket = hash_ff;
endmodule

/* rtl/chkv_queue.sv */
// Short job queue between front end and back end.
module chkv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  chkv_pkg::job_type push_job,
   output logic              q_full,
   input  logic              pop,
   output logic              q_valid,
   output chkv_pkg::job_type q_job
);
   chkv_pkg::job_type           slot_ff [chkv_pkg::Q_DEPTH];
   logic [chkv_pkg::QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [chkv_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign q_full  = cnt_ff == chkv_pkg::QCNT_W'(chkv_pkg::Q_DEPTH);
   assign q_valid = cnt_ff != '0;
   assign q_job   = slot_ff[rp_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == chkv_pkg::QPTR_W'(chkv_pkg::Q_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == chkv_pkg::QPTR_W'(chkv_pkg::Q_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end
endmodule

/* rtl/chkv_back.sv */
// Back end: bucket and node memories, chain walk, clearing sweep, result register.
module chkv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  chkv_pkg::job_type            q_job,
   output logic                         pop,
   output logic                         init_busy,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [1:0]                   status,
   output logic [chkv_pkg::DATA_W-1:0]  data_out
);
   chkv_pkg::link_type              head_mem [chkv_pkg::BUCKETS];
   logic [chkv_pkg::KEY_W-1:0]      key_mem  [chkv_pkg::POOL_NODES];
   logic [chkv_pkg::DATA_W-1:0]     val_mem  [chkv_pkg::POOL_NODES];
   chkv_pkg::link_type              link_mem [chkv_pkg::POOL_NODES];

   chkv_pkg::back_state_type        state_ff, state_in;
   chkv_pkg::job_type               job_ff, job_in;
   logic [chkv_pkg::NODE_BITS-1:0]  cur_ff, cur_in, prev_ff, prev_in;
   logic                            have_prev_ff, have_prev_in;
   logic [chkv_pkg::POOL_CNT_W-1:0] pool_ff, pool_in;
   logic [chkv_pkg::HASH_BITS-1:0]  sweep_ff, sweep_in;
   logic                            init_ff, init_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   chkv_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [chkv_pkg::DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   chkv_pkg::link_type              head_q, link_q;
   logic [chkv_pkg::KEY_W-1:0]      key_q;
   logic [chkv_pkg::DATA_W-1:0]     val_q;
   logic [chkv_pkg::HASH_BITS-1:0]  head_ra, head_wa;
   chkv_pkg::link_type              head_wd, link_wd;
   logic                            head_we, node_we, link_we;
   logic [chkv_pkg::NODE_BITS-1:0]  node_ra, node_wa, link_wa;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q <= head_mem[head_ra];
      if (node_we) begin
         key_mem[node_wa] <= job_ff.key;
         val_mem[node_wa] <= job_ff.data;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      key_q  <= key_mem[node_ra];
      val_q  <= val_mem[node_ra];
      link_q <= link_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chkv_pkg::B_SWEEP;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      have_prev_ff  <= have_prev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      pool_in       = pool_ff;
      sweep_in      = sweep_ff;
      init_in       = init_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      head_ra       = job_ff.bucket;
      head_we       = 1'b0;
      head_wa       = job_ff.bucket;
      head_wd       = '0;
      node_ra       = link_q.idx;
      node_we       = 1'b0;
      node_wa       = pool_ff[chkv_pkg::NODE_BITS-1:0];
      link_we       = 1'b0;
      link_wa       = pool_ff[chkv_pkg::NODE_BITS-1:0];
      link_wd       = head_q;
      case (state_ff)
         chkv_pkg::B_SWEEP: begin
            head_we  = 1'b1;
            head_wa  = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               init_in  = 1'b0;
               state_in = chkv_pkg::B_IDLE;
            end
         end
         chkv_pkg::B_IDLE: begin
            head_ra = q_job.bucket;
            if (q_valid && (!rsp_valid_ff || rsp_tready)) begin
               pop          = 1'b1;
               job_in       = q_job;
               have_prev_in = 1'b0;
               if (q_job.op == chkv_pkg::OP_CLEAR) begin
                  pool_in       = '0;
                  sweep_in      = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = chkv_pkg::ST_OK;
                  rsp_data_in   = '0;
                  state_in      = chkv_pkg::B_SWEEP;
               end else begin
                  state_in = chkv_pkg::B_HEAD;
               end
            end
         end
         chkv_pkg::B_HEAD: begin
            node_ra = head_q.idx;
            cur_in  = head_q.idx;
            if (job_ff.op == chkv_pkg::OP_ADD) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = chkv_pkg::B_IDLE;
               if (pool_ff >= chkv_pkg::POOL_CNT_W'(chkv_pkg::POOL_NODES)) begin
                  rsp_status_in = chkv_pkg::ST_POOL_FULL;
               end else begin
                  rsp_status_in = chkv_pkg::ST_OK;
                  node_we       = 1'b1;
                  link_we       = 1'b1;
                  head_we       = 1'b1;
                  head_wd.vld   = 1'b1;
                  head_wd.idx   = pool_ff[chkv_pkg::NODE_BITS-1:0];
                  pool_in       = pool_ff + 1'b1;
               end
            end else if (!head_q.vld) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = chkv_pkg::ST_NOT_FOUND;
               rsp_data_in   = '0;
               state_in      = chkv_pkg::B_IDLE;
            end else begin
               state_in = chkv_pkg::B_NODE;
            end
         end
         chkv_pkg::B_NODE: begin
            if (key_q == job_ff.key) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = chkv_pkg::ST_OK;
               rsp_data_in   = val_q;
               state_in      = chkv_pkg::B_IDLE;
               if (job_ff.op == chkv_pkg::OP_REMOVE) begin
                  if (have_prev_ff) begin
                     link_we = 1'b1;
                     link_wa = prev_ff;
                     link_wd = link_q;
                  end else begin
                     head_we = 1'b1;
                     head_wd = link_q;
                  end
               end
            end else if (link_q.vld) begin
               prev_in      = cur_ff;
               cur_in       = link_q.idx;
               have_prev_in = 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = chkv_pkg::ST_NOT_FOUND;
               rsp_data_in   = '0;
               state_in      = chkv_pkg::B_IDLE;
            end
         end
         default: state_in = chkv_pkg::B_IDLE;
      endcase
   end

   assign init_busy  = init_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign status     = rsp_status_ff;
   assign data_out   = rsp_data_ff;
endmodule

/* rtl/chained_hash_key_value_store.sv */
// Top level of the chained hash key-value store.
//
//  channel  ports          tdata fields (low bit up)           tuser
//  request  req_t*   in    key_chars[49:0], data_in[81:50]     req_type
//  response rsp_t*   out   data_out[31:0]                      status
//
// Front end: accepts a request, hashes the key letter by letter, then pushes the job once the queue has room.
// Back end: add puts a new node at the chain head; find/remove walk the chain, one node read a cycle.
// Clear sweeps every bucket head, one entry a cycle.
// After reset the same sweep runs and req_tready stays low until it ends.
// The result register holds while rsp_tready is low; the front end keeps
// working into the queue meanwhile.
module chained_hash_key_value_store (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [chkv_pkg::REQ_TDATA_W-1:0]    req_tdata,  // key_chars, data_in, zero pad
   input  logic [1:0]                          req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [chkv_pkg::DATA_W-1:0]         rsp_tdata,  // data_out
   output logic [1:0]                          rsp_tuser   // status
);
   logic              init_busy, push_valid, q_full, q_valid, pop;
   chkv_pkg::job_type push_job, q_job;

   chkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .key_chars  (req_tdata[chkv_pkg::KEY_W-1:0]),
      .data_in    (req_tdata[chkv_pkg::KEY_W +: chkv_pkg::DATA_W]),
      .init_busy  (init_busy),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   chkv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_job      (q_job)
   );

   chkv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (rsp_tuser),
      .data_out   (rsp_tdata)
   );
endmodule

/* rtl/chkv_checker.sv */
// Port-level checks of the key-value store, bound to the top level.
module chkv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [chkv_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [chkv_pkg::DATA_W-1:0]      rsp_tdata,
   input logic [1:0]                       rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != chkv_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("failed transaction carries data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("reserved status code");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while hashing");
endmodule

bind chained_hash_key_value_store chkv_checker u_chkv_checker (.*);

/* tb/chained_hash_key_value_store_tb.sv */
// Testbench for the chained hash key-value store: random and directed requests.
module chained_hash_key_value_store_tb;
   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [chkv_pkg::REQ_TDATA_W-1:0] req_tdata;   // key_chars, data_in, zero pad
   logic [1:0]                       req_tuser;   // req_type
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [chkv_pkg::DATA_W-1:0]      rsp_tdata;   // data_out
   logic [1:0]                       rsp_tuser;   // status

   chained_hash_key_value_store DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   typedef struct packed {
      chkv_pkg::status_type        status;
      logic [chkv_pkg::DATA_W-1:0] data;
   } reply_type;

   // table model
   logic [chkv_pkg::NODE_BITS-1:0] head_idx [chkv_pkg::BUCKETS];
   logic                           head_vld [chkv_pkg::BUCKETS];
   logic [chkv_pkg::KEY_W-1:0]     node_key [chkv_pkg::POOL_NODES];
   logic [chkv_pkg::DATA_W-1:0]    node_val [chkv_pkg::POOL_NODES];
   logic [chkv_pkg::NODE_BITS-1:0] node_nxt [chkv_pkg::POOL_NODES];
   logic                           node_vld [chkv_pkg::POOL_NODES];
   int unsigned                    pool_used;

   reply_type   pending_replies[$];
   int          errors;
   int          replies_seen;
   int          sent_count;
   int          op_count[4];
   int          send_idle_pct;
   int          recv_stall_pct;
   logic [chkv_pkg::KEY_W-1:0] key_bank[$];

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [chkv_pkg::KEY_W-1:0] trim_key(logic [chkv_pkg::KEY_W-1:0] raw);
      logic [chkv_pkg::KEY_W-1:0] k;
      k = '0;
      for (int i = 0; i < chkv_pkg::KEY_LETTERS; i++) begin
         if (raw[i*chkv_pkg::LETTER_BITS +: chkv_pkg::LETTER_BITS] == '0) break;
         k[i*chkv_pkg::LETTER_BITS +: chkv_pkg::LETTER_BITS] =
            raw[i*chkv_pkg::LETTER_BITS +: chkv_pkg::LETTER_BITS];
      end
      return k;
   endfunction

   function automatic logic [chkv_pkg::HASH_BITS-1:0] djb2_bucket(
         logic [chkv_pkg::KEY_W-1:0] k);
      logic [63:0] h;
      h = 64'd5381;
      for (int i = 0; i < chkv_pkg::KEY_LETTERS; i++) begin
         if (k[i*chkv_pkg::LETTER_BITS +: chkv_pkg::LETTER_BITS] == '0) break;
         h = (h << 5) + h + 64'(k[i*chkv_pkg::LETTER_BITS +: chkv_pkg::LETTER_BITS]);
      end
      return h[chkv_pkg::HASH_BITS-1:0];
   endfunction

   function automatic reply_type apply_request(chkv_pkg::op_type op,
                                               logic [chkv_pkg::KEY_W-1:0] raw,
                                               logic [chkv_pkg::DATA_W-1:0] value);
      reply_type r;
      logic [chkv_pkg::KEY_W-1:0] k;
      logic [chkv_pkg::HASH_BITS-1:0] b;
      int unsigned cur, prv, steps;
      logic cur_v, have_prv, hit;
      r.status = chkv_pkg::ST_OK;
      r.data = '0;
      k = trim_key(raw);
      b = djb2_bucket(k);
      case (op)
         chkv_pkg::OP_CLEAR: begin
            for (int i = 0; i < chkv_pkg::BUCKETS; i++) head_vld[i] = 1'b0;
            pool_used = 0;
         end
         chkv_pkg::OP_ADD: begin
            if (pool_used >= chkv_pkg::POOL_NODES) begin
               r.status = chkv_pkg::ST_POOL_FULL;
            end else begin
               node_key[pool_used] = k;
               node_val[pool_used] = value;
               node_nxt[pool_used] = head_idx[b];
               node_vld[pool_used] = head_vld[b];
               head_idx[b] = chkv_pkg::NODE_BITS'(pool_used);
               head_vld[b] = 1'b1;
               pool_used++;
            end
         end
         default: begin
            cur_v = head_vld[b];
            cur = 32'(head_idx[b]);
            prv = 0;
            have_prv = 1'b0;
            hit = 1'b0;
            steps = 0;
            while (cur_v && steps < chkv_pkg::POOL_NODES) begin
               if (node_key[cur] == k) begin
                  hit = 1'b1;
                  break;
               end
               have_prv = 1'b1;
               prv = cur;
               cur_v = node_vld[cur];
               cur = 32'(node_nxt[cur]);
               steps++;
            end
            if (!hit) begin
               r.status = chkv_pkg::ST_NOT_FOUND;
            end else begin
               r.data = node_val[cur];
               if (op == chkv_pkg::OP_REMOVE) begin
                  if (have_prv) begin
                     node_nxt[prv] = node_nxt[cur];
                     node_vld[prv] = node_vld[cur];
                  end else begin
                     head_idx[b] = node_nxt[cur];
                     head_vld[b] = node_vld[cur];
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // one request transaction; expectation computed on acceptance
   task automatic send_request(chkv_pkg::op_type op, logic [chkv_pkg::KEY_W-1:0] raw,
                               logic [chkv_pkg::DATA_W-1:0] value);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(chkv_pkg::REQ_TDATA_W-chkv_pkg::KEY_W-chkv_pkg::DATA_W){1'b0}},
                     value, raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(apply_request(op, raw, value));
      op_count[op]++;
      sent_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response: status %0d data %h",
                                       rsp_tuser, rsp_tdata);
         end else begin
            reply_type e;
            e = pending_replies.pop_front();
            if (rsp_tuser !== e.status || rsp_tdata !== e.data) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected status %0d data %h, got status %0d data %h",
                           e.status, e.data, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (recv_stall_pct > 0) rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      else rsp_tready <= 1'b1;
   end

   function automatic logic [chkv_pkg::KEY_W-1:0] random_word(int len);
      logic [chkv_pkg::KEY_W-1:0] k;
      k = '0;
      for (int i = 0; i < len; i++)
         k[i*chkv_pkg::LETTER_BITS +: chkv_pkg::LETTER_BITS] =
            chkv_pkg::LETTER_BITS'($urandom_range(31, 1));
      return k;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [chkv_pkg::KEY_W-1:0] ab;
      ab = {40'd0, 5'd2, 5'd1};
      send_request(chkv_pkg::OP_FIND, ab, '0);
      send_request(chkv_pkg::OP_REMOVE, ab, '0);
      send_request(chkv_pkg::OP_ADD, ab, 32'h8000_0000);
      send_request(chkv_pkg::OP_ADD, ab, 32'h7fff_ffff);              // duplicate shadows
      send_request(chkv_pkg::OP_FIND, ab, '0);
      send_request(chkv_pkg::OP_REMOVE, ab, '0);
      send_request(chkv_pkg::OP_FIND, ab, '0);
      // junk after end mark and full-width letters
      send_request(chkv_pkg::OP_FIND, {30'h3fff_ffff, 5'd0, 5'd0, 5'd2, 5'd1}, 32'hffff_ffff);
      send_request(chkv_pkg::OP_ADD, {chkv_pkg::KEY_W{1'b1}}, 32'hffff_ffff);
      send_request(chkv_pkg::OP_FIND, {chkv_pkg::KEY_W{1'b1}}, '0);
      send_request(chkv_pkg::OP_ADD, '0, 32'h1234_5678);               // empty key
      send_request(chkv_pkg::OP_FIND, {chkv_pkg::KEY_W{1'b1}} << chkv_pkg::LETTER_BITS, '0);
      send_request(chkv_pkg::OP_FIND, '0, '0);
      send_request(chkv_pkg::OP_REMOVE, {chkv_pkg::KEY_W{1'b1}}, '0);
      send_request(chkv_pkg::OP_REMOVE, ab, '0);
      send_request(chkv_pkg::OP_REMOVE, ab, '0);
      send_request(chkv_pkg::OP_CLEAR, ab, 32'h5555_aaaa);
      send_request(chkv_pkg::OP_FIND, '0, '0);
      send_request(chkv_pkg::OP_ADD, {10{5'd26}}, 32'd0);
      send_request(chkv_pkg::OP_FIND, {10{5'd26}}, '0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      chkv_pkg::op_type op;
      logic [chkv_pkg::KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         if (key_bank.size() == 0 || $urandom_range(3, 0) == 0) begin
            k = random_word($urandom_range(chkv_pkg::KEY_LETTERS, 1));
            if ($urandom_range(7, 0) == 0)
               k = chkv_pkg::KEY_W'($urandom ^ ({$urandom, $urandom} << 18));
            key_bank.push_back(k);
            if (key_bank.size() > 40) void'(key_bank.pop_front());
         end else begin
            k = key_bank[$urandom_range(key_bank.size() - 1, 0)];
         end
         case ($urandom_range(99, 0)) inside
            [0:39]:  op = chkv_pkg::OP_ADD;
            [40:69]: op = chkv_pkg::OP_FIND;
            [70:98]: op = chkv_pkg::OP_REMOVE;
            default: op = chkv_pkg::OP_CLEAR;
         endcase
         send_request(op, k, $urandom);
      end
      wait_drained();
   endtask

   // clear, refill, clear again and refill once more
   task automatic test_clear_reuse();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(chkv_pkg::OP_CLEAR, '0, '0);
      send_request(chkv_pkg::OP_ADD, {40'd0, 5'd1, 5'd1}, 32'd9);
      send_request(chkv_pkg::OP_FIND, {40'd0, 5'd1, 5'd1}, '0);
      send_request(chkv_pkg::OP_CLEAR, '0, '0);
      send_request(chkv_pkg::OP_FIND, {40'd0, 5'd1, 5'd1}, '0);
      send_request(chkv_pkg::OP_ADD, {40'd0, 5'd1, 5'd1}, 32'd7);
      send_request(chkv_pkg::OP_FIND, {40'd0, 5'd1, 5'd1}, '0);
      wait_drained();
   endtask

   initial begin
      errors = 0;
      replies_seen = 0;
      sent_count = 0;
      pool_used = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < chkv_pkg::BUCKETS; i++) begin
         head_vld[i] = 1'b0;
         head_idx[i] = '0;
      end
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = chkv_pkg::OP_ADD;
      rsp_tready = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(240);
      send_idle_pct = 81;
      test_random(240);
      send_idle_pct = 0;
      recv_stall_pct = 81;
      test_random(240);
      send_idle_pct = 18;
      recv_stall_pct = 18;
      test_random(210);
      test_clear_reuse();
      repeat (200) @(posedge clock);
      $display("Sent %0d requests (add %0d, find %0d, remove %0d, clear %0d), %0d responses",
               sent_count, op_count[0], op_count[1], op_count[2], op_count[3], replies_seen);
      $display("Covered duplicates, misses, trimmed keys, clears and idle/stall mixes");
      if (errors == 0 && pending_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule

/* chained_hash_key_value_store.f */
rtl/chkv_pkg.sv
rtl/chkv_front.sv
rtl/chkv_queue.sv
rtl/chkv_back.sv
rtl/chained_hash_key_value_store.sv
rtl/chkv_checker.sv
tb/chained_hash_key_value_store_tb.sv
